FILE: hdl/csp_pkg.sv
// shared types and constants of the cyclic shuffle pointer chase core
`default_nettype none

package csp_pkg;

    localparam int FUNC_W   = 2;
    localparam int WORD_W   = 64;
    localparam int STATUS_W = 2;
    localparam int PASS_W   = 8;
    localparam int ESIZE_W  = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W    = $clog2(WORD_W);

    localparam logic [FUNC_W-1:0] FUNC_INIT    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SHUFFLE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_HOP     = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FINISHED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARRAY_BASE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_SIZE = 2'd3;

    localparam logic [PASS_W-1:0]  PASS_RESET  = 8'd1;
    localparam logic [ESIZE_W-1:0] ESIZE_RESET = 13'd8;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

endpackage

`default_nettype wire

FILE: hdl/csp_ifs.sv
// request and response channel interfaces
`default_nettype none

interface csp_req_if import csp_pkg::*; ;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [WORD_W-1:0]   rand_word;

    modport source (output valid, func, rand_word, input ready);
    modport sink (input valid, func, rand_word, output ready);
endinterface

interface csp_rsp_if import csp_pkg::*; #(parameter int NODE_W = 10);
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   node;
    logic [WORD_W-1:0]   read_address;
    logic [WORD_W-1:0]   visited_sum;
    logic                shuffle_done;
    logic                chase_done;

    modport source (output valid, status, node, read_address, visited_sum, shuffle_done,
                    chase_done, input ready);
    modport sink (input valid, status, node, read_address, visited_sum, shuffle_done,
                  chase_done, output ready);
endinterface

`default_nettype wire

FILE: hdl/csp_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module csp_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/csp_mod_unit.sv
// bit-serial remainder of a 64-bit word by a narrow divisor, one bit per cycle
`default_nettype none

module csp_mod_unit import csp_pkg::*; #(
    parameter int DIV_W = 10
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [WORD_W-1:0] dividend,
    input  wire logic [DIV_W-1:0]  divisor,
    output logic      [DIV_W-1:0]  rem,
    output mod_stat_t              stat
);

    logic [WORD_W-1:0] dividend_reg, dividend_next;
    logic [DIV_W-1:0]  divisor_reg, divisor_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_W:0]    trial;

    always_comb
    begin
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        busy_next     = busy_reg;
        done_next     = 1'b0;
        trial         = {rem_reg, dividend_reg[WORD_W-1]};
        if (start)
        begin
            dividend_next = dividend;
            divisor_next  = divisor;
            rem_next      = '0;
            cnt_next      = '0;
            busy_next     = 1'b1;
        end
        else if (busy_reg)
        begin
            // restoring step: remainder stays below the divisor
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next = DIV_W'(trial - {1'b0, divisor_reg});
            end
            else
            begin
                rem_next = DIV_W'(trial);
            end
            dividend_next = {dividend_reg[WORD_W-2:0], 1'b0};
            cnt_next      = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
    end

    assign rem       = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < divisor_reg))
        else $error("remainder not below divisor");

    a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("remainder unit started while busy");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("done without a finished run");

endmodule

`default_nettype wire

FILE: hdl/cyclic_shuffle_pointer_chase_core.sv
// Successor-table core: builds a single-cycle permutation by Sattolo steps and walks it as a
// dependent pointer chase. One response per request transaction. Initialise writes one table
// entry per cycle over all MAX_NODES entries; a shuffle step waits on the bit-serial remainder
// unit for its done flag, then does two reads and two writes of the table memory and the
// response; a hop does a table read, then address add and node update; and a request that is
// ignored or finds the chase finished goes straight to the response.
// The next request is taken while the previous response still waits in the output register.
`default_nettype none

module cyclic_shuffle_pointer_chase_core import csp_pkg::*; #(
    parameter int MAX_NODES = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data,
    csp_req_if.sink                   req,
    csp_rsp_if.source                 rsp
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int SIZE_W = $clog2(MAX_NODES + 1);
    localparam int HOP_W  = $clog2(MAX_NODES * 255 + 1);
    localparam int PROD_W = NODE_W + ESIZE_W;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_INIT    = 10'b00_0000_0010,
        S_MOD     = 10'b00_0000_0100,
        S_SW_RD0  = 10'b00_0000_1000,
        S_SW_RD1  = 10'b00_0001_0000,
        S_SW_WR0  = 10'b00_0010_0000,
        S_SW_WR1  = 10'b00_0100_0000,
        S_HOP_RD  = 10'b00_1000_0000,
        S_HOP_UPD = 10'b01_0000_0000,
        S_RESP    = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0]  table_size_reg, table_size_next;
    logic [PASS_W-1:0]  pass_count_reg, pass_count_next;
    logic [WORD_W-1:0]  array_base_reg, array_base_next;
    logic [ESIZE_W-1:0] element_size_reg, element_size_next;

    logic [NODE_W-1:0]  shuffle_idx_reg, shuffle_idx_next;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic [WORD_W-1:0]  sum_reg, sum_next;
    logic [HOP_W-1:0]   hops_reg, hops_next;
    logic               table_ready_reg, table_ready_next;

    logic [NODE_W-1:0]   sweep_reg, sweep_next;
    logic [NODE_W-1:0]   ta_reg, ta_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [WORD_W-1:0]   addr_reg, addr_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [NODE_W-1:0]   out_node_reg, out_node_next;
    logic [WORD_W-1:0]   out_addr_reg, out_addr_next;
    logic [WORD_W-1:0]   out_sum_reg, out_sum_next;
    logic                out_sdone_reg, out_sdone_next;
    logic                out_cdone_reg, out_cdone_next;

    logic [SIZE_W-1:0] used_size;
    logic [HOP_W-1:0]  hop_target;
    logic              shuffle_fin;
    logic              chase_fin;

    logic              mem_we;
    logic [NODE_W-1:0] mem_waddr;
    logic [NODE_W-1:0] mem_wdata;
    logic [NODE_W-1:0] mem_raddr;
    logic [NODE_W-1:0] mem_rdata;

    logic              mod_start;
    logic [NODE_W-1:0] mod_rem;
    mod_stat_t         mod_stat;

    csp_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    csp_mod_unit #(
        .DIV_W (NODE_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (req.rand_word),
        .divisor  (shuffle_idx_reg),
        .rem      (mod_rem),
        .stat     (mod_stat)
    );

    // saturate the configured size to the legal range
    always_comb
    begin
        priority if (table_size_reg < SIZE_W'(2))
        begin
            used_size = SIZE_W'(2);
        end
        else if (table_size_reg > SIZE_W'(MAX_NODES))
        begin
            used_size = SIZE_W'(MAX_NODES);
        end
        else
        begin
            used_size = table_size_reg;
        end
    end

    assign hop_target  = HOP_W'(used_size) * HOP_W'(pass_count_reg);
    assign shuffle_fin = table_ready_reg && (shuffle_idx_reg == '0);
    assign chase_fin   = shuffle_fin && (hops_reg >= hop_target);

    // configuration writes
    always_comb
    begin
        table_size_next   = table_size_reg;
        pass_count_next   = pass_count_reg;
        array_base_next   = array_base_reg;
        element_size_next = element_size_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TABLE_SIZE:   table_size_next   = cfg_data[SIZE_W-1:0];
                REG_PASS_COUNT:   pass_count_next   = cfg_data[PASS_W-1:0];
                REG_ARRAY_BASE:   array_base_next   = cfg_data;
                REG_ELEMENT_SIZE: element_size_next = cfg_data[ESIZE_W-1:0];
                default:          table_size_next   = table_size_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        shuffle_idx_next = shuffle_idx_reg;
        node_next        = node_reg;
        sum_next         = sum_reg;
        hops_next        = hops_reg;
        table_ready_next = table_ready_reg;
        sweep_next       = sweep_reg;
        ta_next          = ta_reg;
        prod_next        = prod_reg;
        addr_next        = addr_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_node_next    = out_node_reg;
        out_addr_next    = out_addr_reg;
        out_sum_next     = out_sum_reg;
        out_sdone_next   = out_sdone_reg;
        out_cdone_next   = out_cdone_reg;
        mem_we           = 1'b0;
        mem_waddr        = shuffle_idx_reg;
        mem_wdata        = '0;
        mem_raddr        = shuffle_idx_reg;
        mod_start        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    addr_next = '0;
                    priority if (req.func == FUNC_INIT)
                    begin
                        sweep_next  = '0;
                        status_next = ST_DONE;
                        state_next  = S_INIT;
                    end
                    else if (req.func == FUNC_SHUFFLE && table_ready_reg
                             && shuffle_idx_reg != '0)
                    begin
                        mod_start  = 1'b1;
                        state_next = S_MOD;
                    end
                    else if (req.func == FUNC_HOP && shuffle_fin && !chase_fin)
                    begin
                        state_next = S_HOP_RD;
                    end
                    else
                    begin
                        status_next = (req.func == FUNC_HOP && chase_fin) ? ST_FINISHED
                                                                          : ST_IGNORED;
                        state_next  = S_RESP;
                    end
                end
            end
            S_INIT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = sweep_reg;
                sweep_next = sweep_reg + NODE_W'(1);
                if (sweep_reg == NODE_W'(MAX_NODES - 1))
                begin
                    shuffle_idx_next = NODE_W'(used_size - SIZE_W'(1));
                    node_next        = '0;
                    sum_next         = '0;
                    hops_next        = '0;
                    table_ready_next = 1'b1;
                    state_next       = S_RESP;
                end
            end
            S_MOD:
            begin
                if (mod_stat.done)
                begin
                    state_next = S_SW_RD0;
                end
            end
            S_SW_RD0:
            begin
                mem_raddr  = shuffle_idx_reg;
                state_next = S_SW_RD1;
            end
            S_SW_RD1:
            begin
                mem_raddr  = mod_rem;
                ta_next    = mem_rdata;
                state_next = S_SW_WR0;
            end
            S_SW_WR0:
            begin
                // entry at the index takes the old entry at j
                mem_we     = 1'b1;
                mem_waddr  = shuffle_idx_reg;
                mem_wdata  = mem_rdata;
                state_next = S_SW_WR1;
            end
            S_SW_WR1:
            begin
                mem_we           = 1'b1;
                mem_waddr        = mod_rem;
                mem_wdata        = ta_reg;
                shuffle_idx_next = shuffle_idx_reg - NODE_W'(1);
                status_next      = ST_DONE;
                state_next       = S_RESP;
            end
            S_HOP_RD:
            begin
                mem_raddr  = node_reg;
                prod_next  = PROD_W'(node_reg) * PROD_W'(element_size_reg);
                state_next = S_HOP_UPD;
            end
            S_HOP_UPD:
            begin
                addr_next   = array_base_reg + WORD_W'(prod_reg);
                node_next   = mem_rdata;
                sum_next    = sum_reg + WORD_W'(mem_rdata);
                hops_next   = hops_reg + HOP_W'(1);
                status_next = ST_DONE;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_node_next   = node_reg;
                    out_addr_next   = addr_reg;
                    out_sum_next    = sum_reg;
                    out_sdone_next  = shuffle_fin;
                    out_cdone_next  = chase_fin;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            table_size_reg   <= SIZE_W'(MAX_NODES);
            pass_count_reg   <= PASS_RESET;
            array_base_reg   <= '0;
            element_size_reg <= ESIZE_RESET;
            shuffle_idx_reg  <= '0;
            node_reg         <= '0;
            sum_reg          <= '0;
            hops_reg         <= '0;
            table_ready_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            table_size_reg   <= table_size_next;
            pass_count_reg   <= pass_count_next;
            array_base_reg   <= array_base_next;
            element_size_reg <= element_size_next;
            shuffle_idx_reg  <= shuffle_idx_next;
            node_reg         <= node_next;
            sum_reg          <= sum_next;
            hops_reg         <= hops_next;
            table_ready_reg  <= table_ready_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sweep_reg      <= sweep_next;
        ta_reg         <= ta_next;
        prod_reg       <= prod_next;
        addr_reg       <= addr_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_node_reg   <= out_node_next;
        out_addr_reg   <= out_addr_next;
        out_sum_reg    <= out_sum_next;
        out_sdone_reg  <= out_sdone_next;
        out_cdone_reg  <= out_cdone_next;
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.node         = out_node_reg;
    assign rsp.read_address = out_addr_reg;
    assign rsp.visited_sum  = out_sum_reg;
    assign rsp.shuffle_done = out_sdone_reg;
    assign rsp.chase_done   = out_cdone_reg;

    a_no_write_outside_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_RESP || state_reg == S_MOD) |-> !mem_we)
        else $error("table written outside an operation");

    a_swap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SW_RD0) |-> (shuffle_idx_reg != '0 && mod_rem < shuffle_idx_reg))
        else $error("swap partner not below the shuffle index");

    a_hop_allowed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOP_RD) |-> (shuffle_fin && !chase_fin))
        else $error("hop started out of phase");

    a_mod_only_in_shuffle: assert property (@(posedge clk) disable iff (!rst_n)
        mod_stat.busy |-> (state_reg == S_MOD))
        else $error("remainder unit busy outside a shuffle step");

endmodule

`default_nettype wire
